FILE: rtl/ttlp_pkg.sv
package ttlp_pkg;

    // field and state widths
    localparam int FREQ_W   = 16;
    localparam int DUR_W    = 20;
    localparam int PAUSE_W  = 14;
    localparam int CNT_W    = 11;
    localparam int ACC_W    = 21;
    localparam int PROD_W   = 25;
    localparam int PADDR_W  = 4;
    localparam int PDATA_W  = 32;

    localparam int OUT_DEPTH = 4;
    localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
    localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

    localparam logic [ACC_W-1:0] ACC_CAP    = 21'h1F_FFFF;
    localparam logic [CNT_W-1:0] MAX_EVENTS = 11'd1024;

    // configuration reset values
    localparam logic [FREQ_W-1:0]  FREQ_LIMIT_RST  = 16'd32767;
    localparam logic [DUR_W-1:0]   DUR_LIMIT_RST   = 20'd600000;
    localparam logic [PAUSE_W-1:0] PAUSE_LIMIT_RST = 14'd10000;

    // register indexes
    localparam logic [1:0] REG_FREQ_LIMIT  = 2'd0;
    localparam logic [1:0] REG_DUR_LIMIT   = 2'd1;
    localparam logic [1:0] REG_PAUSE_LIMIT = 2'd2;

    // characters
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_EQUAL = 8'h3D;

    // line keywords: header, name, pause, events
    localparam int KW_NUM    = 4;
    localparam int KW_PAUSE  = 2;
    localparam logic [3:0] KW_POS_MAX = 4'd8;
    localparam logic [7:0] KW_TEXT [KW_NUM][8] = '{
        '{8'h50, 8'h4F, 8'h4F, 8'h4D, 8'h54, 8'h4F, 8'h4E, 8'h45},
        '{8'h6E, 8'h61, 8'h6D, 8'h65, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h70, 8'h61, 8'h75, 8'h73, 8'h65, 8'h00, 8'h00, 8'h00},
        '{8'h65, 8'h76, 8'h65, 8'h6E, 8'h74, 8'h73, 8'h00, 8'h00}
    };
    localparam logic [3:0] KW_LEN [KW_NUM] = '{4'd8, 4'd4, 4'd5, 4'd6};

    typedef enum logic [1:0] {
        LP_LEAD,
        LP_BODY,
        LP_SKIP,
        LP_PAUSE
    } t_line_phase;

    typedef enum logic [1:0] {
        EV_FREQ,
        EV_SEP,
        EV_DUR,
        EV_FAIL
    } t_event_phase;

    typedef enum logic [2:0] {
        NP_IDLE,
        NP_WS,
        NP_START,
        NP_SIGNED,
        NP_DIG,
        NP_END
    } t_num_phase;

    typedef struct packed {
        t_num_phase       ph;
        logic             neg;
        logic [ACC_W-1:0] acc;
    } t_num;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        logic               result_kind;
        logic [FREQ_W-1:0]  frequency_hz;
        logic [DUR_W-1:0]   duration;
        logic [PAUSE_W-1:0] pause_len;
        logic               success;
        logic [CNT_W-1:0]   event_count;
        logic               last;
    } t_out_item;

    localparam logic KIND_EVENT   = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

endpackage

FILE: rtl/tone_text_line_parser.sv
// Tone script line parser. Takes one script byte per request and keeps the whole line
// state in registers, so a byte can be accepted in every cycle: each byte costs one
// multiply-by-ten accumulate and a few character compares. NUL, CR or LF closes a line
// and may produce an event result; the byte marked last produces the end summary, after
// the event of a line it closes, so one byte can give two results. Results leave through
// a four-entry output queue; the input is held off only while the queue has room for
// fewer than two results. Limits are written through the APB-style port while no script
// is in flight: freq_limit at 0x0, duration_limit at 0x4, pause_limit at 0x8.
module tone_text_line_parser
    import ttlp_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,

    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  t_in_item           i_in_data,

    output logic               o_out_valid,
    input  logic               i_out_ready,
    output t_out_item          o_out_data,

    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    function automatic logic is_blank(logic [7:0] c);
        return c == CH_SPACE || c == CH_TAB || c == CH_VT || c == CH_FF;
    endfunction

    function automatic logic is_digit(logic [7:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    function automatic t_num num_feed(t_num n, logic [7:0] c);
        t_num              r;
        logic [3:0]        d;
        logic [PROD_W-1:0] prod;
        logic              dg;
        r    = n;
        d    = c[3:0];
        dg   = is_digit(c);
        prod = ({4'd0, n.acc} << 3) + ({4'd0, n.acc} << 1) + {21'd0, d};
        if (r.ph == NP_WS && !is_blank(c)) begin
            r.ph = NP_START;
        end
        case (r.ph)
            NP_START: begin
                if (c == CH_PLUS || c == CH_MINUS) begin
                    r.neg = (c == CH_MINUS);
                    r.ph  = NP_SIGNED;
                end else if (dg) begin
                    r.acc = {17'd0, d};
                    r.ph  = NP_DIG;
                end else begin
                    r.ph = NP_END;
                end
            end
            NP_SIGNED: begin
                if (dg) begin
                    r.acc = {17'd0, d};
                    r.ph  = NP_DIG;
                end else begin
                    r.ph = NP_END;
                end
            end
            NP_DIG: begin
                if (dg) begin
                    r.acc = (prod > {4'd0, ACC_CAP}) ? ACC_CAP : prod[ACC_W-1:0];
                end else begin
                    r.ph = NP_END;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic t_num pause_feed(t_num n, logic [7:0] c, logic [7:0] delim);
        t_num r;
        r = n;
        if (n.ph == NP_IDLE) begin
            if (c == delim) begin
                r.ph = NP_WS;
            end
        end else begin
            r = num_feed(n, c);
        end
        return r;
    endfunction

    function automatic logic [ACC_W-1:0] num_value(t_num n, logic [ACC_W-1:0] lim);
        logic [ACC_W-1:0] v;
        if (n.acc == '0) begin
            v = '0;
        end else if (n.neg) begin
            v = lim;
        end else begin
            v = (n.acc < lim) ? n.acc : lim;
        end
        return v;
    endfunction

    localparam t_num NUM_START = '{ph: NP_START, neg: 1'b0, acc: '0};
    localparam t_num NUM_IDLE  = '{ph: NP_IDLE,  neg: 1'b0, acc: '0};

    // configuration
    logic [FREQ_W-1:0]  r_freq_limit;
    logic [DUR_W-1:0]   r_dur_limit;
    logic [PAUSE_W-1:0] r_pause_limit;
    logic               cfg_wr;

    // parser state
    t_line_phase        r_line,      n_line;
    t_event_phase       r_ev,        n_ev;
    logic [3:0]         r_pos,       n_pos;
    logic [KW_NUM-1:0]  r_cand,      n_cand;
    t_num               r_freq,      n_freq;
    t_num               r_dur,       n_dur;
    t_num               r_pause,     n_pause;
    t_num               r_pause_alt, n_pause_alt;
    logic [PAUSE_W-1:0] r_stored,    n_stored;
    logic [CNT_W-1:0]   r_cnt,       n_cnt;
    logic               r_ended,     n_ended;

    // per-byte control
    logic               accept;
    logic [7:0]         c;
    logic               line_end;
    logic               take;
    logic               fin;
    logic               do_body;
    logic               do_pause;
    logic               kw_hit;
    logic               kw_hit_pause;
    logic [KW_NUM-1:0]  kw_keep;
    logic               ev_cont;
    logic               ev_valid;
    logic               sum_valid;
    t_out_item          ev_item;
    t_out_item          sum_item;
    logic               sum_ok;

    // output queue
    t_out_item              r_fifo [OUT_DEPTH];
    logic [OUT_PTR_W-1:0]   r_wr_ptr;
    logic [OUT_PTR_W-1:0]   r_rd_ptr;
    logic [OUT_CNT_W-1:0]   r_count;
    logic [1:0]             push_n;
    logic                   pop;

    assign accept   = i_in_valid && o_in_ready;
    assign c        = i_in_data.text_byte;
    assign line_end = (c == CH_NUL) || (c == CH_CR) || (c == CH_LF);
    assign take     = accept && !r_ended && !line_end;
    // a last byte closes the open line after its own character was taken
    assign fin      = accept && !r_ended && (line_end || i_in_data.last_byte);

    always_comb begin
        n_line       = r_line;
        n_ev         = r_ev;
        n_pos        = r_pos;
        n_cand       = r_cand;
        n_freq       = r_freq;
        n_dur        = r_dur;
        n_pause      = r_pause;
        n_pause_alt  = r_pause_alt;
        n_stored     = r_stored;
        n_cnt        = r_cnt;
        n_ended      = r_ended;
        do_body      = 1'b0;
        do_pause     = 1'b0;
        kw_hit       = 1'b0;
        kw_hit_pause = 1'b0;
        kw_keep      = r_cand;
        ev_cont      = 1'b1;
        ev_valid     = 1'b0;
        sum_valid    = 1'b0;
        sum_ok       = 1'b0;
        ev_item      = '0;
        sum_item     = '0;

        if (take) begin
            case (r_line)
                LP_LEAD: begin
                    if (!is_blank(c)) begin
                        if (c == CH_HASH) begin
                            n_line = LP_SKIP;
                        end else begin
                            n_line  = LP_BODY;
                            do_body = 1'b1;
                        end
                    end
                end
                LP_BODY:  do_body  = 1'b1;
                LP_PAUSE: do_pause = 1'b1;
                default: ;
            endcase
        end

        if (do_body) begin
            for (int i = 0; i < KW_NUM; i++) begin
                if (r_cand[i]) begin
                    if (r_pos >= KW_LEN[i] || KW_TEXT[i][r_pos[2:0]] != c) begin
                        kw_keep[i] = 1'b0;
                    end else if (r_pos + 4'd1 == KW_LEN[i]) begin
                        kw_hit = 1'b1;
                        if (i == KW_PAUSE) begin
                            kw_hit_pause = 1'b1;
                        end
                    end
                end
            end
            if (r_cand != '0) begin
                if (kw_hit) begin
                    n_line = kw_hit_pause ? LP_PAUSE : LP_SKIP;
                end else begin
                    n_cand = kw_keep;
                    if (r_pos < KW_POS_MAX) begin
                        n_pos = r_pos + 4'd1;
                    end
                end
            end
            if (!kw_hit) begin
                if (n_ev == EV_FREQ) begin
                    if (r_freq.ph == NP_DIG && !is_digit(c)) begin
                        n_ev = EV_SEP;
                    end else begin
                        n_freq  = num_feed(r_freq, c);
                        ev_cont = 1'b0;
                        if (n_freq.ph == NP_END) begin
                            n_ev = EV_FAIL;
                        end
                    end
                end
                if (ev_cont && n_ev == EV_SEP) begin
                    if (is_blank(c) || c == CH_COMMA || c == CH_SEMI) begin
                        ev_cont = 1'b0;
                    end else begin
                        n_ev = EV_DUR;
                    end
                end
                if (ev_cont && n_ev == EV_DUR) begin
                    n_dur = num_feed(r_dur, c);
                end
            end
        end

        if (do_pause) begin
            n_pause     = pause_feed(r_pause, c, CH_COLON);
            n_pause_alt = pause_feed(r_pause_alt, c, CH_EQUAL);
        end

        if (fin) begin
            if (n_line == LP_PAUSE) begin
                if (n_pause.ph != NP_IDLE) begin
                    n_stored = PAUSE_W'(num_value(n_pause, {7'd0, r_pause_limit}));
                end else if (n_pause_alt.ph != NP_IDLE) begin
                    n_stored = PAUSE_W'(num_value(n_pause_alt, {7'd0, r_pause_limit}));
                end
            end else if (n_line == LP_BODY && n_ev == EV_DUR && n_dur.acc != '0
                         && n_cnt < MAX_EVENTS) begin
                ev_valid             = 1'b1;
                ev_item.result_kind  = KIND_EVENT;
                ev_item.frequency_hz = FREQ_W'(num_value(n_freq, {5'd0, r_freq_limit}));
                ev_item.duration     = DUR_W'(num_value(n_dur, {1'b0, r_dur_limit}));
                n_cnt                = n_cnt + 11'd1;
            end
            n_line      = LP_LEAD;
            n_ev        = EV_FREQ;
            n_pos       = '0;
            n_cand      = '1;
            n_freq      = NUM_START;
            n_dur       = NUM_START;
            n_pause     = NUM_IDLE;
            n_pause_alt = NUM_IDLE;
        end

        if (accept && !r_ended && c == CH_NUL) begin
            n_ended = 1'b1;
        end

        if (accept && i_in_data.last_byte) begin
            sum_valid            = 1'b1;
            sum_ok               = (n_cnt != '0);
            sum_item.result_kind = KIND_SUMMARY;
            sum_item.pause_len   = sum_ok ? n_stored : '0;
            sum_item.success     = sum_ok;
            sum_item.event_count = n_cnt;
            sum_item.last        = 1'b1;
            // start over for the next script
            n_line      = LP_LEAD;
            n_ev        = EV_FREQ;
            n_pos       = '0;
            n_cand      = '1;
            n_freq      = NUM_START;
            n_dur       = NUM_START;
            n_pause     = NUM_IDLE;
            n_pause_alt = NUM_IDLE;
            n_stored    = '0;
            n_cnt       = '0;
            n_ended     = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line      <= LP_LEAD;
            r_ev        <= EV_FREQ;
            r_pos       <= '0;
            r_cand      <= '1;
            r_freq      <= NUM_START;
            r_dur       <= NUM_START;
            r_pause     <= NUM_IDLE;
            r_pause_alt <= NUM_IDLE;
            r_stored    <= '0;
            r_cnt       <= '0;
            r_ended     <= 1'b0;
        end else begin
            r_line      <= n_line;
            r_ev        <= n_ev;
            r_pos       <= n_pos;
            r_cand      <= n_cand;
            r_freq      <= n_freq;
            r_dur       <= n_dur;
            r_pause     <= n_pause;
            r_pause_alt <= n_pause_alt;
            r_stored    <= n_stored;
            r_cnt       <= n_cnt;
            r_ended     <= n_ended;
        end
    end

    // output queue, up to two pushes per cycle
    assign push_n      = {1'b0, ev_valid} + {1'b0, sum_valid};
    assign pop         = o_out_valid && i_out_ready;
    assign o_out_valid = (r_count != '0);
    assign o_out_data  = r_fifo[r_rd_ptr];
    assign o_in_ready  = (r_count <= OUT_CNT_W'(OUT_DEPTH - 2));

    always_ff @(posedge i_clk) begin
        if (ev_valid) begin
            r_fifo[r_wr_ptr] <= ev_item;
            if (sum_valid) begin
                r_fifo[r_wr_ptr + OUT_PTR_W'(1)] <= sum_item;
            end
        end else if (sum_valid) begin
            r_fifo[r_wr_ptr] <= sum_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + OUT_PTR_W'(push_n);
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + OUT_PTR_W'(1);
            end
            r_count <= r_count + OUT_CNT_W'(push_n) - OUT_CNT_W'(pop);
        end
    end

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_freq_limit  <= FREQ_LIMIT_RST;
            r_dur_limit   <= DUR_LIMIT_RST;
            r_pause_limit <= PAUSE_LIMIT_RST;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_FREQ_LIMIT:  r_freq_limit  <= pwdata[FREQ_W-1:0];
                REG_DUR_LIMIT:   r_dur_limit   <= pwdata[DUR_W-1:0];
                REG_PAUSE_LIMIT: r_pause_limit <= pwdata[PAUSE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_FREQ_LIMIT:  prdata = {16'd0, r_freq_limit};
            REG_DUR_LIMIT:   prdata = {12'd0, r_dur_limit};
            REG_PAUSE_LIMIT: prdata = {18'd0, r_pause_limit};
            default:         prdata = '0;
        endcase
    end

endmodule
